@@ src/epsdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to date package
// Widths, constants, the pipeline item and the calendar helper functions.
// ----------------------------------------------------------------------------
package epsdt_pkg;

  localparam int YEAR_W  = 12;
  localparam int SEC_W   = 31;
  localparam int DAYS_W  = 15;
  localparam int SOD_W   = 17;
  localparam int Y400_W  = 9;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SECS_W  = 6;
  localparam int YLEN_W  = 9;

  // At most 68 whole years fit into a 31-bit count of seconds.
  localparam int YEAR_STEPS  = 68;
  localparam int MONTH_STEPS = 11;
  localparam int SPLIT_STAGES = 6;
  localparam int LATENCY = SPLIT_STAGES + YEAR_STEPS + MONTH_STEPS;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR_RESET = 12'd2010;
  localparam logic [SOD_W-1:0]  SECONDS_PER_DAY  = 17'd86400;
  localparam logic [11:0]       SECONDS_PER_HOUR = 12'd3600;
  localparam logic [5:0]        SECONDS_PER_MIN  = 6'd60;

  // Reciprocals for exact division by a constant: (x * RECIP) >> SHIFT.
  localparam logic [24:0] DAY_RECIP  = 25'd25451659; // 1/675 over 24 bits
  localparam int          DAY_SHIFT  = 34;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;     // 1/225 over 13 bits
  localparam int          HOUR_SHIFT = 21;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;     // 1/15 over 10 bits
  localparam int          MIN_SHIFT  = 14;

  localparam logic [YLEN_W-1:0] DAYS_LEAP_YEAR   = 9'd366;
  localparam logic [YLEN_W-1:0] DAYS_COMMON_YEAR = 9'd365;
  localparam logic [Y400_W-1:0] CYCLE_LAST       = 9'd399;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

  typedef struct packed {
    logic [DAYS_W-1:0]  days;
    logic [YEAR_W-1:0]  year;
    logic [Y400_W-1:0]  y400;
    logic [MONTH_W-1:0] month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SECS_W-1:0]  second;
  } epsdt_item_t;

  // The year modulo 400 decides everything: 400 is a multiple of 4 and 100.
  function automatic logic is_leap(input logic [Y400_W-1:0] y400);
    logic by4;
    logic century;
    by4     = (y400[1:0] == 2'b00);
    century = (y400 == 9'd0) || (y400 == 9'd100) || (y400 == 9'd200) ||
              (y400 == 9'd300);
    return (by4 && !century) || (y400 == 9'd0);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ src/epsdt_split.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to date: front split
// Splits the count into whole days and hour, minute and second of the day,
// using reciprocal multiplications, and prepares the year search.
// ----------------------------------------------------------------------------
module epsdt_split (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [epsdt_pkg::SEC_W-1:0]   total_seconds,
  input  logic [epsdt_pkg::YEAR_W-1:0]  epoch_year,
  output logic                          out_valid,
  output epsdt_pkg::epsdt_item_t        out_item
);
  import epsdt_pkg::*;

  function automatic logic [Y400_W-1:0] mod400(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] r;
    r = y;
    if (r >= YEAR_W'(3200)) r = r - YEAR_W'(3200);
    if (r >= YEAR_W'(1600)) r = r - YEAR_W'(1600);
    if (r >= YEAR_W'(800))  r = r - YEAR_W'(800);
    if (r >= YEAR_W'(400))  r = r - YEAR_W'(400);
    return r[Y400_W-1:0];
  endfunction

  logic [SPLIT_STAGES-1:0] valid;

  // Stage 1: whole days.
  logic [SEC_W-1:0]  t1;
  logic [DAYS_W-1:0] days1;
  logic [YEAR_W-1:0] year1;
  logic [Y400_W-1:0] y4001;
  logic [48:0]       day_prod;

  // Stage 2: seconds of the day.
  logic [SOD_W-1:0]  sod2;
  logic [DAYS_W-1:0] days2;
  logic [YEAR_W-1:0] year2;
  logic [Y400_W-1:0] y4002;
  logic [31:0]       day_secs;
  logic [SEC_W-1:0]  sod_full;

  // Stage 3: hour.
  logic [SOD_W-1:0]  sod3;
  logic [HOUR_W-1:0] hour3;
  logic [DAYS_W-1:0] days3;
  logic [YEAR_W-1:0] year3;
  logic [Y400_W-1:0] y4003;
  logic [26:0]       hour_prod;

  // Stage 4: seconds of the hour.
  logic [11:0]       rem4;
  logic [HOUR_W-1:0] hour4;
  logic [DAYS_W-1:0] days4;
  logic [YEAR_W-1:0] year4;
  logic [Y400_W-1:0] y4004;
  logic [SOD_W-1:0]  hour_secs;

  // Stage 5: minute.
  logic [11:0]       rem5;
  logic [MIN_W-1:0]  min5;
  logic [HOUR_W-1:0] hour5;
  logic [DAYS_W-1:0] days5;
  logic [YEAR_W-1:0] year5;
  logic [Y400_W-1:0] y4005;
  logic [20:0]       min_prod;

  // Stage 6: second.
  logic [11:0]       min_secs;

  assign day_prod  = 49'(total_seconds[SEC_W-1:7]) * 49'(DAY_RECIP);
  assign day_secs  = 32'(days1) * 32'(SECONDS_PER_DAY);
  assign sod_full  = t1 - day_secs[SEC_W-1:0];
  assign hour_prod = 27'(sod2[SOD_W-1:4]) * 27'(HOUR_RECIP);
  assign hour_secs = SOD_W'(hour3) * SOD_W'(SECONDS_PER_HOUR);
  assign min_prod  = 21'(rem4[11:2]) * 21'(MIN_RECIP);
  assign min_secs  = 12'(min5) * 12'(SECONDS_PER_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[SPLIT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    t1    <= total_seconds;
    days1 <= day_prod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
    year1 <= epoch_year;
    y4001 <= mod400(epoch_year);

    sod2  <= sod_full[SOD_W-1:0];
    days2 <= days1;
    year2 <= year1;
    y4002 <= y4001;

    sod3  <= sod2;
    hour3 <= hour_prod[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
    days3 <= days2;
    year3 <= year2;
    y4003 <= y4002;

    rem4  <= 12'(sod3 - hour_secs);
    hour4 <= hour3;
    days4 <= days3;
    year4 <= year3;
    y4004 <= y4003;

    rem5  <= rem4;
    min5  <= min_prod[MIN_SHIFT+MIN_W-1:MIN_SHIFT];
    hour5 <= hour4;
    days5 <= days4;
    year5 <= year4;
    y4005 <= y4004;

    out_item.second <= SECS_W'(rem5 - min_secs);
    out_item.minute <= min5;
    out_item.hour   <= hour5;
    out_item.days   <= days5;
    out_item.year   <= year5;
    out_item.y400   <= y4005;
    out_item.month  <= MONTH_JAN;
  end

  assign out_valid = valid[SPLIT_STAGES-1];

  // Remainders of exact divisions stay below their divisors, and the hour below 24.
  assert property (@(posedge clk) disable iff (rst)
    valid[2] |-> sod3 < SECONDS_PER_DAY)
    else $error("seconds of day out of range");
  assert property (@(posedge clk) disable iff (rst)
    valid[4] |-> rem5 < SECONDS_PER_HOUR)
    else $error("seconds of hour out of range");
  assert property (@(posedge clk) disable iff (rst)
    valid[3] |-> hour4 < HOUR_W'(24))
    else $error("hour out of range");

endmodule

@@ src/epsdt_year_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to date: year step
// Removes one whole year from the day count when it still fits.
// ----------------------------------------------------------------------------
module epsdt_year_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  epsdt_pkg::epsdt_item_t in_item,
  output logic                   out_valid,
  output epsdt_pkg::epsdt_item_t out_item
);
  import epsdt_pkg::*;

  logic [YLEN_W-1:0] ylen;
  logic              fits;
  epsdt_item_t       item_next;

  assign ylen = is_leap(in_item.y400) ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
  assign fits = (in_item.days >= DAYS_W'(ylen));

  always_comb begin
    item_next = in_item;
    if (fits) begin
      item_next.days = in_item.days - DAYS_W'(ylen);
      item_next.year = in_item.year + YEAR_W'(1);
      item_next.y400 = (in_item.y400 == CYCLE_LAST) ? '0 : in_item.y400 + Y400_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= item_next;
  end

endmodule

@@ src/epsdt_month_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to date: month step
// Moves past one month when the day count still covers it.
// ----------------------------------------------------------------------------
module epsdt_month_stage #(
  parameter int MONTH_NUM = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  epsdt_pkg::epsdt_item_t in_item,
  output logic                   out_valid,
  output epsdt_pkg::epsdt_item_t out_item
);
  import epsdt_pkg::*;

  localparam logic [MONTH_W-1:0] THIS_MONTH = MONTH_W'(MONTH_NUM);

  logic [DAY_W-1:0] mlen;
  epsdt_item_t      item_next;

  assign mlen = month_len(THIS_MONTH, is_leap(in_item.y400));

  // Only an item still searching at this month may advance.
  always_comb begin
    item_next = in_item;
    if (in_item.month == THIS_MONTH && in_item.days >= DAYS_W'(mlen)) begin
      item_next.days  = in_item.days - DAYS_W'(mlen);
      item_next.month = in_item.month + MONTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= item_next;
  end

endmodule

@@ src/epoch_seconds_to_date_time.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to date and time
// Converts a count of seconds since 1 January of the epoch year into a
// Gregorian calendar date and time of day.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present total_seconds with start high; the transaction is taken
//   at a rising edge where start is high and busy is low. busy is high
//   during reset and clears once rst is low; it stays low from then on, so a new
//   transaction may follow every cycle.
//   Output: each result appears on the cal_* ports for exactly one cycle
//   with done high, once its input has passed every pipeline stage. Results
//   leave in input order; the receiver cannot stall them.
//   Throughput: one conversion per cycle. The latency is set by the
//   pipeline of 6 front stages (day split and reciprocal divisions),
//   68 year-removal stages and 11 month-removal stages.
//   Configuration: epoch_year is written through cfg_valid/cfg_ready with
//   cfg_data; cfg_ready is always high. Write it only when no transaction
//   is in flight.
//   Reset: rst is synchronous; it empties the pipeline and sets epoch_year
//   to 2010.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date_time (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [epsdt_pkg::SEC_W-1:0]   total_seconds,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [epsdt_pkg::YEAR_W-1:0]  cfg_data,
  output logic                          done,
  output logic [epsdt_pkg::YEAR_W-1:0]  cal_year,
  output logic [epsdt_pkg::MONTH_W-1:0] cal_month,
  output logic [epsdt_pkg::DAY_W-1:0]   cal_day,
  output logic [epsdt_pkg::HOUR_W-1:0]  cal_hour,
  output logic [epsdt_pkg::MIN_W-1:0]   cal_minute,
  output logic [epsdt_pkg::SECS_W-1:0]  cal_second
);
  import epsdt_pkg::*;

  logic [YEAR_W-1:0] epoch_year;
  logic              accept;

  logic [YEAR_STEPS:0]  year_valid;
  epsdt_item_t          year_item [YEAR_STEPS+1];
  logic [MONTH_STEPS:0] month_valid;
  epsdt_item_t          month_item [MONTH_STEPS+1];

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      epoch_year <= EPOCH_YEAR_RESET;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        epoch_year <= cfg_data;
      end
    end
  end

  epsdt_split u_split (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .total_seconds(total_seconds),
    .epoch_year   (epoch_year),
    .out_valid    (year_valid[0]),
    .out_item     (year_item[0])
  );

  for (genvar i = 0; i < YEAR_STEPS; i++) begin : g_year
    epsdt_year_stage u_year (
      .clk      (clk),
      .rst      (rst),
      .in_valid (year_valid[i]),
      .in_item  (year_item[i]),
      .out_valid(year_valid[i+1]),
      .out_item (year_item[i+1])
    );
  end

  assign month_valid[0] = year_valid[YEAR_STEPS];
  assign month_item[0]  = year_item[YEAR_STEPS];

  for (genvar m = 0; m < MONTH_STEPS; m++) begin : g_month
    epsdt_month_stage #(
      .MONTH_NUM(m + 1)
    ) u_month (
      .clk      (clk),
      .rst      (rst),
      .in_valid (month_valid[m]),
      .in_item  (month_item[m]),
      .out_valid(month_valid[m+1]),
      .out_item (month_item[m+1])
    );
  end

  assign done       = month_valid[MONTH_STEPS];
  assign cal_year   = month_item[MONTH_STEPS].year;
  assign cal_month  = month_item[MONTH_STEPS].month;
  assign cal_day    = month_item[MONTH_STEPS].days[DAY_W-1:0] + DAY_W'(1);
  assign cal_hour   = month_item[MONTH_STEPS].hour;
  assign cal_minute = month_item[MONTH_STEPS].minute;
  assign cal_second = month_item[MONTH_STEPS].second;

  // Every accepted transaction comes out of the pipeline with done high.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result missing after pipeline latency");
  // The year search must have finished before the months are removed.
  assert property (@(posedge clk) disable iff (rst)
    month_valid[0] |-> month_item[0].days < DAYS_W'(DAYS_LEAP_YEAR))
    else $error("day count still spans a whole year");
  assert property (@(posedge clk) disable iff (rst)
    done |-> cal_month != '0 && cal_month <= MONTH_W'(12) && cal_day != '0)
    else $error("calendar date out of range");
  assert property (@(posedge clk) disable iff (rst)
    done |-> cal_minute < MIN_W'(60) && cal_second < SECS_W'(60))
    else $error("time of day out of range");

endmodule

@@ dv/epoch_seconds_to_date_time_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to date and time testbench
// Runs second counts through the converter under a series of epoch years,
// with a behavioural calendar conversion in the bench predicting each date.
// Each result strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date_time_tb;
  import epsdt_pkg::*;

  localparam logic [SEC_W-1:0] MAX_SECONDS = '1;
  localparam int unsigned DAY_SECONDS = 86400;
  localparam int PHASES = 8;
  localparam int RANDOM_PER_PHASE = 119;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                              31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SECS_W-1:0]  second;
  } cal_date_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [SEC_W-1:0]   total_seconds = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [YEAR_W-1:0]  cfg_data = '0;
  logic               done;
  logic [YEAR_W-1:0]  cal_year;
  logic [MONTH_W-1:0] cal_month;
  logic [DAY_W-1:0]   cal_day;
  logic [HOUR_W-1:0]  cal_hour;
  logic [MIN_W-1:0]   cal_minute;
  logic [SECS_W-1:0]  cal_second;

  logic [SEC_W-1:0]  pending_seconds [$];
  cal_date_t         expected_dates [$];
  cal_date_t         oldest_date;
  logic [YEAR_W-1:0] epoch_now = EPOCH_YEAR_RESET;
  logic [YEAR_W-1:0] epoch_plan [PHASES];
  bit                tight_phase = 1'b0;
  int unsigned       gap_left;
  int unsigned       dates_seen = 0;
  int unsigned       fail_count = 0;

  epoch_seconds_to_date_time u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .total_seconds (total_seconds),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .cal_year      (cal_year),
    .cal_month     (cal_month),
    .cal_day       (cal_day),
    .cal_hour      (cal_hour),
    .cal_minute    (cal_minute),
    .cal_second    (cal_second)
  );

  always #2 clk = ~clk;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(input int unsigned m,
                                               input int unsigned y);
    if (m == MONTH_FEB)
      return leap_year(y) ? 29 : 28;
    return MONTH_DAYS[m - 1];
  endfunction

  // Peels whole years and then whole months off the day count; the year keeps
  // counting past twelve bits and only its low bits are reported.
  function automatic cal_date_t convert_to_date(input logic [SEC_W-1:0] secs,
                                                input logic [YEAR_W-1:0] epoch);
    int unsigned days;
    int unsigned sod;
    int unsigned yr;
    int unsigned mon;
    cal_date_t   d;
    days = secs / DAY_SECONDS;
    sod  = secs % DAY_SECONDS;
    yr   = 32'(epoch);
    mon  = 1;
    while (days >= year_length(yr)) begin
      days -= year_length(yr);
      yr++;
    end
    while (mon < 12 && days >= month_length(mon, yr)) begin
      days -= month_length(mon, yr);
      mon++;
    end
    d.year   = YEAR_W'(yr);
    d.month  = MONTH_W'(mon);
    d.day    = DAY_W'(days + 1);
    d.hour   = HOUR_W'(sod / 3600);
    d.minute = MIN_W'((sod % 3600) / 60);
    d.second = SECS_W'(sod % 60);
    return d;
  endfunction

  function automatic longint seconds_in_years(input logic [YEAR_W-1:0] epoch,
                                              input int unsigned count);
    longint total;
    total = 0;
    for (int unsigned i = 0; i < count; i++)
      total += longint'(year_length(epoch + i)) * DAY_SECONDS;
    return total;
  endfunction

  function automatic logic [SEC_W-1:0] clip_seconds(input longint v);
    if (v < 0)
      return '0;
    if (v > longint'(MAX_SECONDS))
      return MAX_SECONDS;
    return SEC_W'(v);
  endfunction

  // Mixes uniform counts with counts that land on or next to day and year
  // boundaries, where the subtraction chains are most likely to slip.
  function automatic logic [SEC_W-1:0] random_seconds(input logic [YEAR_W-1:0] epoch);
    int unsigned pick;
    longint      v;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      v = longint'($urandom & 32'h7FFF_FFFF);
    else if (pick < 6)
      v = longint'($urandom_range(0, 4 * 366 * DAY_SECONDS - 1));
    else if (pick < 8)
      v = longint'($urandom_range(0, 24855)) * DAY_SECONDS +
          ($urandom_range(0, 1) ? longint'(DAY_SECONDS - 1) : 0);
    else
      v = seconds_in_years(epoch, $urandom_range(1, 67)) +
          longint'($urandom_range(0, 7200)) - 3600;
    return clip_seconds(v);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 100);
  endfunction

  task automatic note_failure(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_failure($sformatf("date %0d %s: got %0d, expected %0d",
                             dates_seen, name, got, want));
  endtask

  task automatic write_epoch(input logic [YEAR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    epoch_now = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_until_idle();
    do
      @(negedge clk);
    while (pending_seconds.size() != 0 || start || expected_dates.size() != 0);
  endtask

  // Transaction driver: the prediction is queued at the edge that takes the
  // transaction, using the epoch year in force at that moment.
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy)
        expected_dates.push_back(convert_to_date(total_seconds, epoch_now));
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_seconds.size() != 0) begin
          start         <= 1'b1;
          total_seconds <= pending_seconds.pop_front();
          gap_left      <= tight_phase ? 0 : pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_dates.size() == 0) begin
        note_failure($sformatf("date %0d arrived with nothing expected", dates_seen));
      end else begin
        oldest_date = expected_dates.pop_front();
        check_field("year",   32'(cal_year),   32'(oldest_date.year));
        check_field("month",  32'(cal_month),  32'(oldest_date.month));
        check_field("day",    32'(cal_day),    32'(oldest_date.day));
        check_field("hour",   32'(cal_hour),   32'(oldest_date.hour));
        check_field("minute", 32'(cal_minute), 32'(oldest_date.minute));
        check_field("second", 32'(cal_second), 32'(oldest_date.second));
      end
      dates_seen++;
    end
  end

  initial begin
    // Year 0 is a leap year, 2100 is a century that is not, 2000 one that
    // is, and 4095 pushes the reported year past twelve bits.
    epoch_plan = '{EPOCH_YEAR_RESET, 12'd1970, 12'd2100, 12'd0, 12'd4095,
                   12'd2000, 12'd0, EPOCH_YEAR_RESET};
    epoch_plan[6] = YEAR_W'($urandom_range(0, 4095));
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0)
        write_epoch(epoch_plan[p]);
      @(negedge clk);
      tight_phase = (p % 3 == 1);
      if (p == 0) begin
        pending_seconds.push_back('0);
        pending_seconds.push_back(SEC_W'(DAY_SECONDS - 1));
        pending_seconds.push_back(SEC_W'(DAY_SECONDS));
        pending_seconds.push_back(SEC_W'(59 * DAY_SECONDS - 1));
        pending_seconds.push_back(SEC_W'(59 * DAY_SECONDS));
        pending_seconds.push_back(SEC_W'(seconds_in_years(epoch_now, 1) - 1));
        // Two common years on from the reset epoch lies 29 February.
        pending_seconds.push_back(SEC_W'(seconds_in_years(epoch_now, 2) +
                                         59 * DAY_SECONDS));
        pending_seconds.push_back(MAX_SECONDS);
      end else begin
        pending_seconds.push_back(SEC_W'(59 * DAY_SECONDS));
        pending_seconds.push_back(SEC_W'(seconds_in_years(epoch_now, 1) - 1));
        pending_seconds.push_back(MAX_SECONDS);
      end
      repeat (RANDOM_PER_PHASE)
        pending_seconds.push_back(random_seconds(epoch_now));
      wait_until_idle();
    end
    repeat (LATENCY + 16) @(posedge clk);
    while (expected_dates.size() != 0) begin
      oldest_date = expected_dates.pop_front();
      note_failure($sformatf("expected date %0d-%0d-%0d never arrived",
                             oldest_date.year, oldest_date.month, oldest_date.day));
    end
    if (fail_count == 0) begin
      $display("** epoch_seconds_to_date_time: PASSED **");
    end else begin
      $display("** epoch_seconds_to_date_time: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("** epoch_seconds_to_date_time: FAILED **");
    $finish;
  end

endmodule
